// File: rtl/mnee_pkg.sv
// Shared types and constants for the MIDI note event encoder.
// No dependencies; imported by mnee_event_fmt and the top level.
package mnee_pkg;

  // Tick counter width used for delta computation (valid range 8..32).
  localparam int TIME_BITS   = 32;
  // VLQ groups of 7 bits needed to cover a full delta.
  localparam int VLQ_MAX     = (TIME_BITS + 6) / 7;
  localparam int VLQ_BITS    = VLQ_MAX * 7;
  localparam int GRP_W       = $clog2(VLQ_MAX + 1);
  localparam int GIDX_W      = $clog2(VLQ_MAX);
  // Longest byte run for one item: VLQ plus status, pitch, velocity.
  localparam int FRAME_BYTES = VLQ_MAX + 3;
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // Input payload layout on s_axis_tdata, lowest bit first.
  localparam int EVT_TIME_W  = 32;
  localparam int TIME_LSB    = 0;
  localparam int NOTE_ON_LSB = TIME_LSB + EVT_TIME_W;
  localparam int PITCH_LSB   = NOTE_ON_LSB + 1;
  localparam int VEL_LSB     = PITCH_LSB + 7;
  localparam int IN_FIELD_W  = VEL_LSB + 7;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OPCODE_W    = 2;

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL = 1'b0,
    CFG_PROGRAM = 1'b1
  } cfg_idx_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_NOTE  = 2'd0,
    OP_START = 2'd1,
    OP_END   = 2'd2
  } opcode_e;

  // MIDI byte codes.
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
  localparam logic [7:0] META_PREFIX     = 8'hFF;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;
  localparam logic [7:0] DELTA_ZERO      = 8'h00;
  localparam logic [3:0] DRUM_CHANNEL    = 4'd9;

  // Bytes produced by one input item, first byte in element 0.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]            len;
  } frame_t;

  // Update of the running previous-time register.
  typedef struct packed {
    logic                 load;
    logic [TIME_BITS-1:0] value;
  } time_upd_t;

endpackage

// File: rtl/mnee_event_fmt.sv
// Formats one input item into its track byte run (VLQ delta, status, data).
// Depends on mnee_pkg.
module mnee_event_fmt (
  input  mnee_pkg::opcode_e              opcode_i,
  input  logic [mnee_pkg::TIME_BITS-1:0] event_time_i,
  input  logic                           note_on_i,
  input  logic [6:0]                     pitch_i,
  input  logic [6:0]                     velocity_i,
  input  logic [3:0]                     channel_i,
  input  logic [6:0]                     program_i,
  input  logic [mnee_pkg::TIME_BITS-1:0] prev_time_i,
  output mnee_pkg::frame_t               frame_o,
  output mnee_pkg::time_upd_t            time_upd_o
);
  import mnee_pkg::*;

  logic [TIME_BITS-1:0]               delta;
  logic [VLQ_BITS-1:0]                delta_ext;
  logic [VLQ_MAX-1:0][6:0]            grp;
  logic [GRP_W-1:0]                   ngrp;
  logic [LEN_W-1:0]                   ngrp_len;
  logic [FRAME_BYTES-1:0][7:0]        vlq;
  logic [GIDX_W-1:0]                  sel;
  logic [7:0]                         status;

  always_comb begin
    delta     = event_time_i - prev_time_i;
    delta_ext = VLQ_BITS'(delta);
    for (int g = 0; g < VLQ_MAX; g++) begin
      grp[g] = delta_ext[g*7 +: 7];
    end

    // Count groups up to the highest nonzero one; zero still takes one byte.
    ngrp = GRP_W'(1);
    for (int g = 1; g < VLQ_MAX; g++) begin
      if (grp[g] != 7'd0) begin
        ngrp = GRP_W'(g + 1);
      end
    end
    ngrp_len = LEN_W'(ngrp);

    // Most significant group first; continuation bit on all but the last.
    vlq = '0;
    for (int k = 0; k < VLQ_MAX; k++) begin
      sel    = GIDX_W'(int'(ngrp) - 1 - k);
      vlq[k] = {(GRP_W'(k + 1) != ngrp), grp[sel]};
    end

    status = {(note_on_i ? STATUS_NOTE_ON : STATUS_NOTE_OFF), channel_i};

    frame_o          = '0;
    time_upd_o.load  = 1'b0;
    time_upd_o.value = event_time_i;

    case (opcode_i)
      OP_NOTE: begin
        for (int k = 0; k < FRAME_BYTES; k++) begin
          if (LEN_W'(k) < ngrp_len) begin
            frame_o.bytes[k] = vlq[k];
          end else if (LEN_W'(k) == ngrp_len) begin
            frame_o.bytes[k] = status;
          end else if (LEN_W'(k) == ngrp_len + LEN_W'(1)) begin
            frame_o.bytes[k] = {1'b0, pitch_i};
          end else if (LEN_W'(k) == ngrp_len + LEN_W'(2)) begin
            frame_o.bytes[k] = note_on_i ? {1'b0, velocity_i} : 8'h00;
          end
        end
        frame_o.len     = ngrp_len + LEN_W'(3);
        time_upd_o.load = 1'b1;
      end
      OP_START: begin
        frame_o.bytes[0] = DELTA_ZERO;
        frame_o.bytes[1] = {STATUS_PROGRAM, channel_i};
        frame_o.bytes[2] = {1'b0, program_i};
        frame_o.len      = (channel_i == DRUM_CHANNEL) ? '0 : LEN_W'(3);
        time_upd_o.load  = 1'b1;
        time_upd_o.value = '0;
      end
      OP_END: begin
        frame_o.bytes[0] = DELTA_ZERO;
        frame_o.bytes[1] = META_PREFIX;
        frame_o.bytes[2] = META_END_TRACK;
        frame_o.bytes[3] = 8'h00;
        frame_o.len      = LEN_W'(4);
      end
      default: begin
        frame_o.len = '0;
      end
    endcase
  end

endmodule

// File: rtl/midi_note_event_encoder.sv
// Top level of the MIDI note event encoder: input transaction capture, frame
// register, byte serializer and output register. Depends on mnee_pkg and
// mnee_event_fmt.
//
// Path: an item is loaded into the frame register when its input transaction
//   is accepted; its bytes then move from the frame register to the output
//   register, which drives m_axis.
// Throughput: one byte per cycle on m_axis while m_axis_tready is high. An item
//   holds the frame register until its last byte moves on: a note event has
//   4..8 bytes, a track item 3 or 4. An item without bytes (a start on the drum
//   channel, an unknown opcode) leaves the frame register invalid. The next
//   item is taken in the cycle the last byte of the current one moves to the
//   output register, so back-to-back items stream without gaps.
// Reset: asynchronous, active low; clears the configuration, the previous
//   time, the frame and output valid flags. No clearing pass is needed.
module midi_note_event_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [mnee_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mnee_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: event_time[31:0], note_on[32], pitch[39:33], velocity[46:40], 0
  input  logic [mnee_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [mnee_pkg::OPCODE_W-1:0]   s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [7:0]                      m_axis_tdata,
  // tlast: last_byte
  output logic                            m_axis_tlast
);
  import mnee_pkg::*;

  // Configuration registers.
  logic [3:0]           channel_q, channel_d;
  logic [6:0]           program_q, program_d;

  // Running time of the last note event.
  logic [TIME_BITS-1:0] prev_time_q, prev_time_d;

  // Frame register holding the pending byte run of one item.
  logic                 frame_valid_q, frame_valid_d;
  frame_t               frame_q;
  logic [IDX_W-1:0]     idx_q, idx_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;

  frame_t               frame_new;
  time_upd_t            time_upd;
  logic                 in_xact;
  logic                 out_load;
  logic                 frame_adv;
  logic                 at_last;
  logic                 frame_done;

  // Build the byte run straight from the incoming transaction.
  mnee_event_fmt u_fmt (
    .opcode_i     (opcode_e'(s_axis_tuser)),
    .event_time_i (s_axis_tdata[TIME_LSB +: TIME_BITS]),
    .note_on_i    (s_axis_tdata[NOTE_ON_LSB]),
    .pitch_i      (s_axis_tdata[PITCH_LSB +: 7]),
    .velocity_i   (s_axis_tdata[VEL_LSB +: 7]),
    .channel_i    (channel_q),
    .program_i    (program_q),
    .prev_time_i  (prev_time_q),
    .frame_o      (frame_new),
    .time_upd_o   (time_upd)
  );

  // Output register takes a byte whenever it is empty or being drained.
  assign out_load   = !out_valid_q || m_axis_tready;
  assign frame_adv  = frame_valid_q && out_load;
  assign at_last    = (LEN_W'(idx_q) + LEN_W'(1)) == frame_q.len;
  assign frame_done = frame_adv && at_last;

  // Accept a new item once the frame register is free or empties this cycle.
  assign s_axis_tready = !frame_valid_q || frame_done;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    channel_d = channel_q;
    program_d = program_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL: channel_d = cfg_wdata_i[3:0];
        CFG_PROGRAM: program_d = cfg_wdata_i[6:0];
        default:     channel_d = channel_q;
      endcase
    end
  end

  always_comb begin
    prev_time_d   = prev_time_q;
    frame_valid_d = frame_valid_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q;

    // Advance through the run one byte per output slot.
    if (frame_adv) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (frame_done) begin
      frame_valid_d = 1'b0;
    end

    // Load a new run; items that produce no bytes only update state.
    if (in_xact) begin
      frame_valid_d = (frame_new.len != '0);
      idx_d         = '0;
      if (time_upd.load) begin
        prev_time_d = time_upd.value;
      end
    end

    if (out_load) begin
      out_valid_d = frame_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q     <= '0;
      program_q     <= '0;
      prev_time_q   <= '0;
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      channel_q     <= channel_d;
      program_q     <= program_d;
      prev_time_q   <= prev_time_d;
      frame_valid_q <= frame_valid_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      frame_q <= frame_new;
    end
    if (frame_adv) begin
      out_byte_q <= frame_q.bytes[idx_q];
      out_last_q <= at_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/mnee_checker.sv
// Port-level checks for the MIDI note event encoder, bound to the top level.
// Depends only on the handshake and output ports of the top level.
module mnee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic in_xact;
  logic out_xact;

  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign out_xact = m_axis_tvalid && m_axis_tready;

  // Hold a stalled output transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Bytes of one item leave without gaps.
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a byte run");

  // A fresh run starts only after a matching input transaction.
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_xact, 2))
    else $error("output run without a matching input transaction");

  // Nothing is presented right out of reset.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind midi_note_event_encoder mnee_checker u_mnee_checker (.*);

// File: bench/tb_midi_note_event_encoder.sv
// Self-checking bench for midi_note_event_encoder: drives note and track items on s_axis,
// predicts the track byte stream and compares every m_axis byte and its tlast flag.
// Depends on mnee_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb_midi_note_event_encoder;
  import mnee_pkg::*;

  // Opcode that the encoder must drop without bytes or state change.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  // VLQ continuation flag on every delta byte but the last.
  localparam logic [7:0] VLQ_CONT = 8'h80;
  // Length byte of the end-of-track meta event.
  localparam logic [7:0] META_LEN_ZERO = 8'h00;
  // Cycles to let an item without bytes clear the pipeline before a register write.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 85;
  localparam int MAX_REPORTS = 60;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [31:0]         event_time;
    logic                note_on;
    logic [6:0]          pitch;
    logic [6:0]          velocity;
  } note_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } track_byte_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [OPCODE_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;

  midi_note_event_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Items waiting for the driver, and bytes the encoder still owes us.
  note_item_t  pending_items[$];
  track_byte_t expected_bytes[$];
  note_item_t  driven_item;

  // Shadow copies of the encoder registers and its running tick.
  logic [3:0]           chan_cfg;
  logic [6:0]           prog_cfg;
  logic [TIME_BITS-1:0] last_tick;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int random_count;
  logic [31:0] track_tick;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Work out the bytes one accepted item should produce and queue them in order,
  // flagging the final byte of the run.
  function automatic void encode_track_bytes(input note_item_t it);
    logic [7:0]           run[FRAME_BYTES];
    logic [6:0]           grp[VLQ_MAX];
    logic [TIME_BITS-1:0] delta;
    track_byte_t          out_entry;
    int                   count;
    int                   n;
    count = 0;
    n = 0;
    case (it.opcode)
      OP_NOTE: begin
        // Delta wraps modulo the tick width, so a backward step encodes as a huge gap.
        delta = it.event_time[TIME_BITS-1:0] - last_tick;
        last_tick = it.event_time[TIME_BITS-1:0];
        do begin
          grp[n] = delta[6:0];
          n++;
          delta = delta >> 7;
        end while (delta != 0 && n < VLQ_MAX);
        // Emit the groups most significant first.
        for (int i = n - 1; i >= 0; i--) begin
          run[count] = (i > 0) ? (VLQ_CONT | {1'b0, grp[i]}) : {1'b0, grp[i]};
          count++;
        end
        run[count] = {it.note_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF, chan_cfg};
        run[count + 1] = {1'b0, it.pitch};
        // Note-off always carries zero velocity.
        run[count + 2] = it.note_on ? {1'b0, it.velocity} : 8'h00;
        count += 3;
      end
      OP_START: begin
        last_tick = '0;
        // Drum channel gets no program change.
        if (chan_cfg != DRUM_CHANNEL) begin
          run[0] = DELTA_ZERO;
          run[1] = {STATUS_PROGRAM, chan_cfg};
          run[2] = {1'b0, prog_cfg};
          count = 3;
        end
      end
      OP_END: begin
        run[0] = DELTA_ZERO;
        run[1] = META_PREFIX;
        run[2] = META_END_TRACK;
        run[3] = META_LEN_ZERO;
        count = 4;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < count; k++) begin
      out_entry.value = run[k];
      out_entry.last  = (k == count - 1);
      expected_bytes.insert(expected_bytes.size(), out_entry);
    end
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_payload(input note_item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[TIME_LSB +: EVT_TIME_W] = it.event_time;
    d[NOTE_ON_LSB]            = it.note_on;
    d[PITCH_LSB +: 7]         = it.pitch;
    d[VEL_LSB +: 7]           = it.velocity;
    return d;
  endfunction

  function automatic void push_item(input logic [OPCODE_W-1:0] op, input logic [31:0] tick,
                                    input logic on, input logic [6:0] pitch,
                                    input logic [6:0] vel);
    note_item_t item;
    item.opcode     = op;
    item.event_time = tick;
    item.note_on    = on;
    item.pitch      = pitch;
    item.velocity   = vel;
    pending_items.insert(pending_items.size(), item);
    // Dropped opcodes do not count toward the stimulus budget.
    if (op != OP_UNUSED) begin
      random_count++;
    end
  endfunction

  // Push an item with random payload; the encoder ignores it except for notes.
  function automatic void push_random_fields(input logic [OPCODE_W-1:0] op,
                                             input logic [31:0] tick);
    push_item(op, tick, 1'($urandom_range(1)), 7'($urandom_range(127)),
              7'($urandom_range(127)));
  endfunction

  // Tick advance spread over every VLQ length.
  function automatic logic [31:0] next_step();
    case ($urandom_range(9))
      0:       return 32'd0;
      1, 2, 3, 4: return 32'($urandom_range(127, 1));
      5, 6:    return 32'($urandom_range(16383, 128));
      7:       return 32'($urandom_range(2097151, 16384));
      8:       return 32'($urandom_range(268435455, 2097152));
      default: return $urandom;
    endcase
  endfunction

  // One well-formed track with random content, sprinkled with dropped opcodes,
  // backward ticks and the odd missing start or end.
  function automatic void push_random_track();
    int notes;
    if ($urandom_range(7) != 0) begin
      push_random_fields(OP_START, $urandom);
      track_tick = '0;
    end
    notes = $urandom_range(10, 1);
    for (int i = 0; i < notes; i++) begin
      case ($urandom_range(15))
        0: push_random_fields(OP_UNUSED, $urandom);
        1: push_random_fields(OP_NOTE, $urandom);
        2: push_random_fields(2'($urandom_range(3)), $urandom);
        default: begin
          track_tick += next_step();
          push_random_fields(OP_NOTE, track_tick);
        end
      endcase
    end
    if ($urandom_range(7) != 0) begin
      push_random_fields(OP_END, $urandom);
    end
  endfunction

  // Write one register; the shadow copy follows the write edge.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CHANNEL) begin
      chan_cfg = value[3:0];
    end else begin
      prog_cfg = value[6:0];
    end
  endtask

  // Hold until every item is taken and every byte has come out, then let any
  // byteless item drain out of the pipeline.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [3:0] chan, input logic [6:0] prog,
                             input int send_pct, input int recv_pct);
    wait_idle();
    write_reg(CFG_CHANNEL, CFG_DATA_W'(chan));
    write_reg(CFG_PROGRAM, prog);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Input driver: predict on every accepted transaction, then load the next
  // item or idle at random.
  always @(posedge clk_i) begin : item_driver
    note_item_t next_item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_track_bytes(driven_item);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          driven_item = next_item;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_payload(next_item);
          s_axis_tuser  <= next_item.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each accepted byte with the oldest expectation,
  // then stall the stream at random.
  always @(posedge clk_i) begin : byte_monitor
    track_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h tlast %0b", m_axis_tdata,
                                    m_axis_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.value) begin
            report_mismatch($sformatf("byte %02h, expected %02h", m_axis_tdata, want.value));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("tlast %0b on byte %02h, expected %0b", m_axis_tlast,
                                      m_axis_tdata, want.last));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_CHANNEL;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_NOTE;
    m_axis_tready  = 1'b0;
    chan_cfg       = '0;
    prog_cfg       = '0;
    last_tick      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    random_count   = 0;
    track_tick     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed track on channel 0: every VLQ length at its lower edge, wrap on a
    // backward tick, note-off velocity, dropped opcode, ignored payloads.
    start_phase(4'd0, 7'd0, 0, 0);
    push_item(OP_START, 32'd0, 1'b0, 7'd0, 7'd0);
    push_item(OP_NOTE, 32'd0, 1'b1, 7'd0, 7'd127);
    push_item(OP_NOTE, 32'd127, 1'b1, 7'd127, 7'd1);
    push_item(OP_NOTE, 32'd255, 1'b0, 7'd60, 7'd127);
    push_item(OP_NOTE, 32'd16638, 1'b1, 7'd61, 7'd64);
    push_item(OP_NOTE, 32'd33022, 1'b0, 7'd62, 7'd0);
    push_item(OP_NOTE, 32'd2130174, 1'b1, 7'd63, 7'd100);
    push_item(OP_NOTE, 32'd270565630, 1'b1, 7'd64, 7'd101);
    push_item(OP_NOTE, 32'hFFFF_FFFF, 1'b0, 7'd65, 7'd102);
    push_item(OP_NOTE, 32'd0, 1'b1, 7'd66, 7'd103);
    push_item(OP_NOTE, 32'd5, 1'b1, 7'd67, 7'd104);
    push_item(OP_NOTE, 32'd3, 1'b1, 7'd68, 7'd105);
    push_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127);
    push_item(OP_END, 32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127);
    push_item(OP_START, 32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127);
    push_item(OP_NOTE, 32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127);
    push_item(OP_NOTE, 32'hFFFF_FFFF, 1'b0, 7'd127, 7'd127);
    push_item(OP_END, 32'd0, 1'b0, 7'd0, 7'd0);

    // Drum channel: start clears the tick but sends nothing.
    start_phase(DRUM_CHANNEL, 7'd77, 0, 0);
    push_item(OP_NOTE, 32'd500, 1'b1, 7'd36, 7'd90);
    push_item(OP_START, 32'd0, 1'b0, 7'd0, 7'd0);
    push_item(OP_NOTE, 32'd200, 1'b1, 7'd38, 7'd80);
    push_item(OP_UNUSED, 32'd0, 1'b0, 7'd0, 7'd0);
    push_item(OP_END, 32'd0, 1'b0, 7'd0, 7'd0);

    // Random tracks across the idling mixes; each phase drains fully first.
    start_phase(4'd15, 7'd127, 0, 0);
    random_count = 0;
    while (random_count < RANDOM_PER_PHASE) push_random_track();

    start_phase(DRUM_CHANNEL, 7'($urandom_range(127)), 54, 0);
    random_count = 0;
    while (random_count < RANDOM_PER_PHASE) push_random_track();

    start_phase(4'($urandom_range(15)), 7'($urandom_range(127)), 0, 54);
    random_count = 0;
    while (random_count < RANDOM_PER_PHASE) push_random_track();

    start_phase(4'($urandom_range(15)), 7'd0, 17, 17);
    random_count = 0;
    while (random_count < RANDOM_PER_PHASE) push_random_track();

    // Drain and watch a little longer for stray bytes.
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("midi_note_event_encoder verification clean");
    end else begin
      $display("midi_note_event_encoder verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("midi_note_event_encoder verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/mnee_pkg.sv
rtl/mnee_event_fmt.sv
rtl/midi_note_event_encoder.sv
rtl/mnee_checker.sv
bench/tb_midi_note_event_encoder.sv
